/* design/hrus_pkg.sv */
`default_nettype none

package hrus_pkg;

  // Section of the request a byte belongs to
  typedef enum logic [2:0] {
    SecMethod  = 3'd0,
    SecUrl     = 3'd1,
    SecVersion = 3'd2,
    SecHeaders = 3'd3,
    SecBody    = 3'd4,
    SecDelim   = 3'd5
  } sec_e;

  // URL verdict reported on the closing space or on an early last byte
  typedef enum logic [1:0] {
    VerdictNone    = 2'd0,
    VerdictAccept  = 2'd1,
    VerdictDefault = 2'd2,
    VerdictReject  = 2'd3
  } verdict_e;

  // Request status per byte
  typedef enum logic [1:0] {
    StatusProgress  = 2'd0,
    StatusHeaderEnd = 2'd1,
    StatusTruncated = 2'd2
  } status_e;

  // Escape decoder phase
  typedef enum logic [1:0] {
    PctIdle   = 2'd0,
    PctFirst  = 2'd1,
    PctSecond = 2'd2
  } pct_e;

  // Characters the splitter and screen look for
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChPct    = 8'h25;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5a;
  localparam logic [7:0] ChCaseOf = 8'h20;
  localparam logic [7:0] ChDig0   = 8'h30;
  localparam logic [7:0] ChDig2   = 8'h32;
  localparam logic [7:0] ChDig3   = 8'h33;
  localparam logic [7:0] ChDig4   = 8'h34;
  localparam logic [7:0] ChDig6   = 8'h36;
  localparam logic [7:0] ChLowerF = 8'h66;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  // Result word
  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] section;
    logic [1:0] url_verdict;
    logic [1:0] request_status;
    logic       last_out;
  } out_t;

  // Allowed escapes: %20 %23 %26 %3f %40
  function automatic logic escape_ok(input logic [7:0] a, input logic [7:0] b);
    logic ok;
    ok = ((a == ChDig2) && ((b == ChDig0) || (b == ChDig3) || (b == ChDig6))) ||
         ((a == ChDig3) && (b == ChLowerF)) ||
         ((a == ChDig4) && (b == ChDig0));
    return ok;
  endfunction

endpackage

`default_nettype wire

/* design/http_request_url_screen.sv */
`default_nettype none

// Channel  Direction  Payload               Handshake
// in       input      hrus_pkg::in_t        in_valid_i / in_stall_o
// out      output     hrus_pkg::out_t       out_valid_o / out_stall_i
//
// One byte per cycle while the output is not stalled: each word is decoded by a
// single pass of logic from the parser state registers into the result register.
// Throughput is set by the result register, which is refilled in the cycle
// it is taken. Reset (rst_ni low, asynchronous) puts the parser in the method
// section with the URL screen cleared. The input stalls only while a result
// waits and the output is stalled.

module http_request_url_screen (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  hrus_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output hrus_pkg::out_t     out_data_o
);

  hrus_pkg::sec_e  section_q, section_d;
  hrus_pkg::pct_e  pct_phase_q, pct_phase_d;
  logic [1:0]      url_len_q, url_len_d;
  logic [7:0]      pct_first_q, pct_first_d;
  logic [7:0]      prev1_q, prev1_d;
  logic [7:0]      prev2_q, prev2_d;
  logic            url_rej_q, url_rej_d;
  logic [1:0]      delim_q, delim_d;
  logic            out_valid_q;
  hrus_pkg::out_t  out_data_q, res;
  logic            in_acc;
  logic [7:0]      b;
  logic [7:0]      c;

  // Take a new word unless a result is waiting on a stalled output
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign b          = in_data_i.data_byte;

  // Lowercase A-Z
  always_comb begin
    if (b inside {[hrus_pkg::ChUpperA:hrus_pkg::ChUpperZ]}) begin
      c = b + hrus_pkg::ChCaseOf;
    end else begin
      c = b;
    end
  end

  // Next parser state and result for this word
  always_comb begin
    section_d   = section_q;
    pct_phase_d = pct_phase_q;
    url_len_d   = url_len_q;
    pct_first_d = pct_first_q;
    prev1_d     = prev1_q;
    prev2_d     = prev2_q;
    url_rej_d   = url_rej_q;
    delim_d     = delim_q;

    res.byte_out       = b;
    res.section        = hrus_pkg::SecBody;
    res.url_verdict    = hrus_pkg::VerdictNone;
    res.request_status = hrus_pkg::StatusProgress;
    res.last_out       = in_data_i.end_of_message;

    case (section_q)
      hrus_pkg::SecMethod: begin
        if (b == hrus_pkg::ChSpace) begin
          res.section = hrus_pkg::SecDelim;
          section_d   = hrus_pkg::SecUrl;
        end else begin
          res.section = hrus_pkg::SecMethod;
        end
      end

      hrus_pkg::SecUrl: begin
        if (b == hrus_pkg::ChSpace) begin
          // Verdict on the closing space
          res.section = hrus_pkg::SecDelim;
          if (url_len_q == 2'd0) begin
            res.url_verdict = hrus_pkg::VerdictReject;
          end else if (url_len_q == 2'd1) begin
            res.url_verdict = hrus_pkg::VerdictDefault;
          end else if (url_rej_q || (pct_phase_q != hrus_pkg::PctIdle) ||
                       (prev1_q == hrus_pkg::ChDot)) begin
            res.url_verdict = hrus_pkg::VerdictReject;
          end else begin
            res.url_verdict = hrus_pkg::VerdictAccept;
          end
          section_d = hrus_pkg::SecVersion;
          delim_d   = 2'd0;
        end else begin
          res.section = hrus_pkg::SecUrl;
          if (url_len_q == 2'd0) begin
            // Skip the leading byte
            url_len_d = 2'd1;
            prev1_d   = '0;
            prev2_d   = '0;
          end else begin
            res.byte_out = c;

            // Track percent escapes
            case (pct_phase_q)
              hrus_pkg::PctFirst: begin
                pct_first_d = c;
                pct_phase_d = hrus_pkg::PctSecond;
              end
              hrus_pkg::PctSecond: begin
                if (!hrus_pkg::escape_ok(pct_first_q, c)) begin
                  url_rej_d = 1'b1;
                end
                pct_phase_d = hrus_pkg::PctIdle;
              end
              default: begin
                if (c == hrus_pkg::ChPct) begin
                  pct_phase_d = hrus_pkg::PctFirst;
                end
              end
            endcase

            // Screen traversal, double slash, colon, leading double backslash
            if ((prev2_q == hrus_pkg::ChDot) && (prev1_q == hrus_pkg::ChDot) &&
                ((c == hrus_pkg::ChSlash) || (c == hrus_pkg::ChBslash))) begin
              url_rej_d = 1'b1;
            end
            if ((prev1_q == hrus_pkg::ChSlash) && (c == hrus_pkg::ChSlash)) begin
              url_rej_d = 1'b1;
            end
            if (c == hrus_pkg::ChColon) begin
              url_rej_d = 1'b1;
            end
            if ((url_len_q == 2'd2) && (prev1_q == hrus_pkg::ChBslash) &&
                (c == hrus_pkg::ChBslash)) begin
              url_rej_d = 1'b1;
            end

            prev2_d = prev1_q;
            prev1_d = c;
            if (url_len_q != 2'd3) begin
              url_len_d = url_len_q + 2'd1;
            end
          end
        end
      end

      hrus_pkg::SecVersion: begin
        if ((delim_q == 2'd1) && (b == hrus_pkg::ChLf)) begin
          res.section = hrus_pkg::SecDelim;
          section_d   = hrus_pkg::SecHeaders;
          delim_d     = 2'd0;
        end else begin
          res.section = hrus_pkg::SecVersion;
          delim_d     = (b == hrus_pkg::ChCr) ? 2'd1 : 2'd0;
        end
      end

      hrus_pkg::SecHeaders: begin
        if ((delim_q == 2'd3) && (b == hrus_pkg::ChLf)) begin
          res.section        = hrus_pkg::SecDelim;
          res.request_status = hrus_pkg::StatusHeaderEnd;
          section_d          = hrus_pkg::SecBody;
          delim_d            = 2'd0;
        end else begin
          res.section = hrus_pkg::SecHeaders;
          if (b == hrus_pkg::ChCr) begin
            delim_d = (delim_q == 2'd2) ? 2'd3 : 2'd1;
          end else if ((b == hrus_pkg::ChLf) && (delim_q == 2'd1)) begin
            delim_d = 2'd2;
          end else begin
            delim_d = 2'd0;
          end
        end
      end

      default: begin
        res.section = hrus_pkg::SecBody;
      end
    endcase

    // Last byte: flag early end, then drop back to the start of a request
    if (in_data_i.end_of_message) begin
      if ((section_d == hrus_pkg::SecMethod) || (section_d == hrus_pkg::SecUrl)) begin
        res.url_verdict = hrus_pkg::VerdictReject;
      end
      if ((section_d == hrus_pkg::SecMethod) || (section_d == hrus_pkg::SecUrl) ||
          (section_d == hrus_pkg::SecVersion) || (section_d == hrus_pkg::SecHeaders)) begin
        res.request_status = hrus_pkg::StatusTruncated;
      end
      section_d   = hrus_pkg::SecMethod;
      pct_phase_d = hrus_pkg::PctIdle;
      url_len_d   = 2'd0;
      pct_first_d = '0;
      prev1_d     = '0;
      prev2_d     = '0;
      url_rej_d   = 1'b0;
      delim_d     = 2'd0;
    end
  end

  // Parser state: advance on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_q   <= hrus_pkg::SecMethod;
      pct_phase_q <= hrus_pkg::PctIdle;
      url_len_q   <= 2'd0;
      pct_first_q <= '0;
      prev1_q     <= '0;
      prev2_q     <= '0;
      url_rej_q   <= 1'b0;
      delim_q     <= 2'd0;
    end else if (in_acc) begin
      section_q   <= section_d;
      pct_phase_q <= pct_phase_d;
      url_len_q   <= url_len_d;
      pct_first_q <= pct_first_d;
      prev1_q     <= prev1_d;
      prev2_q     <= prev2_d;
      url_rej_q   <= url_rej_d;
      delim_q     <= delim_d;
    end
  end

  // Result valid: set on accept, clear once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* design/hrus_checker.sv */
`default_nettype none

module hrus_checker (
  input wire             clk_i,
  input wire             rst_ni,
  input wire             in_valid_i,
  input wire             in_stall_o,
  input hrus_pkg::in_t   in_data_i,
  input wire             out_valid_o,
  input wire             out_stall_i,
  input hrus_pkg::out_t  out_data_o
);

  // Stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result word changed");

  // A verdict comes only on the closing space or on an early last byte
  a_verdict_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.url_verdict != hrus_pkg::VerdictNone)) |->
    ((out_data_o.section == hrus_pkg::SecDelim) || out_data_o.last_out))
    else $error("url verdict outside the URL close");

  // Header end is reported on a delimiter byte only
  a_header_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.request_status == hrus_pkg::StatusHeaderEnd)) |->
    (out_data_o.section == hrus_pkg::SecDelim))
    else $error("header end on a non-delimiter byte");

  // Truncation is reported on the last byte only, never in the body
  a_truncated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.request_status == hrus_pkg::StatusTruncated)) |->
    (out_data_o.last_out && (out_data_o.section != hrus_pkg::SecBody)))
    else $error("truncation flagged on a wrong byte");

endmodule

bind http_request_url_screen hrus_checker u_hrus_checker (.*);

`default_nettype wire
